/* rtl/core/rational_arithmetic_unit_defines.svh */
// Assertion macros for the rational arithmetic unit.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH

// Same-cycle implication.
`define RAU_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RAU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/rau_pkg.sv */
// Shared types and constants of the rational arithmetic unit.
// No dependencies; used by the interfaces, controller, datapath and top level.
`timescale 1ns / 1ps

package rau_pkg;

  localparam int FIELD_BITS = 32;
  localparam int ACT_BITS   = 3;

  typedef logic [ACT_BITS-1:0] act_t;

  localparam act_t ACT_MUL = 3'd0;
  localparam act_t ACT_DIV = 3'd1;
  localparam act_t ACT_ADD = 3'd2;
  localparam act_t ACT_SUB = 3'd3;
  localparam act_t ACT_CMP = 3'd4;

  // Datapath command issued by the controller each cycle.
  typedef enum logic [3:0] {
    DP_IDLE,
    DP_LOAD,
    DP_MUL_A,
    DP_MUL_B,
    DP_MUL_C,
    DP_SUM,
    DP_GCD,
    DP_DIV,
    DP_OUT
  } dp_op_e;

  // Datapath status back to the controller.
  typedef struct packed {
    logic gcd_done;
    logic g_gt1;
  } dp_stat_t;

endpackage

/* rtl/core/rau_if.sv */
// Valid/ready channel interfaces for operand and result transactions.
// Depends on rau_pkg for field widths.
`timescale 1ns / 1ps

interface rau_in_if import rau_pkg::*;;
  logic                         valid;
  logic                         ready;
  act_t                         action;
  logic signed [FIELD_BITS-1:0] a_num;
  logic        [FIELD_BITS-1:0] a_den;
  logic signed [FIELD_BITS-1:0] b_num;
  logic        [FIELD_BITS-1:0] b_den;

  modport source (output valid, action, a_num, a_den, b_num, b_den, input ready);
  modport sink   (input valid, action, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_out_if import rau_pkg::*;;
  logic                         valid;
  logic                         ready;
  logic signed [FIELD_BITS-1:0] res_num;
  logic        [FIELD_BITS-1:0] res_den;
  logic                         is_less;
  logic                         is_greater;

  modport source (output valid, res_num, res_den, is_less, is_greater, input ready);
  modport sink   (input valid, res_num, res_den, is_less, is_greater, output ready);
endinterface

/* rtl/core/rational_arithmetic_unit.sv */
// Rational arithmetic unit: multiplies, divides, adds, subtracts or compares two
// fractions (signed numerator, unsigned denominator) of WORD_BITS bits, wrapping
// products and sums to WORD_BITS bits; add and subtract are reduced by the gcd.
// One transaction is in flight at a time. Multiply, divide and compare make two
// passes through the shared multiplier and then an output write; unused action
// codes go straight to the output write. Add and subtract make a third multiplier
// pass, a sum, a binary gcd (one subtract or shift per cycle, data dependent) and,
// when the gcd exceeds 1, a bit-serial division of numerator and denominator by
// it, before the output write. The output register lets a new transaction be
// accepted while the previous result still waits to be taken.
`timescale 1ns / 1ps

module rational_arithmetic_unit import rau_pkg::*; #(
  parameter int WORD_BITS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rau_in_if.sink     in_i,
  rau_out_if.source  out_o
);

  dp_op_e   op;
  dp_stat_t stat;

  rau_ctrl #(
    .WORD_BITS (WORD_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_action_i (in_i.action),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .op_o        (op)
  );

  rau_datapath #(
    .WORD_BITS (WORD_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .op_i         (op),
    .stat_o       (stat),
    .action_i     (in_i.action),
    .a_num_i      (in_i.a_num),
    .a_den_i      (in_i.a_den),
    .b_num_i      (in_i.b_num),
    .b_den_i      (in_i.b_den),
    .res_num_o    (out_o.res_num),
    .res_den_o    (out_o.res_den),
    .is_less_o    (out_o.is_less),
    .is_greater_o (out_o.is_greater)
  );

endmodule

/* rtl/core/rau_datapath.sv */
// Datapath: operand registers, shared multiplier, binary gcd and restoring divider.
// Depends on rau_pkg; sequenced by rau_ctrl through dp_op_e commands.
`timescale 1ns / 1ps

module rau_datapath import rau_pkg::*; #(
  parameter int WORD_BITS = 32
) (
  input  logic                         clk_i,
  input  dp_op_e                       op_i,
  output dp_stat_t                     stat_o,
  input  act_t                         action_i,
  input  logic signed [FIELD_BITS-1:0] a_num_i,
  input  logic        [FIELD_BITS-1:0] a_den_i,
  input  logic signed [FIELD_BITS-1:0] b_num_i,
  input  logic        [FIELD_BITS-1:0] b_den_i,
  output logic signed [FIELD_BITS-1:0] res_num_o,
  output logic        [FIELD_BITS-1:0] res_den_o,
  output logic                         is_less_o,
  output logic                         is_greater_o
);

  localparam int W  = WORD_BITS;
  localparam int PW = 2 * W + 2;
  localparam int KW = $clog2(W);

  function automatic logic signed [W:0] sx(input logic [W-1:0] v);
    return signed'({v[W-1], v});
  endfunction

  function automatic logic signed [W:0] zx(input logic [W-1:0] v);
    return signed'({1'b0, v});
  endfunction

  act_t                act_q;
  logic [W-1:0]        an_q, ad_q, bn_q, bd_q;
  logic signed [PW-1:0] mult_q, p0_q, p1_q;
  logic [W-1:0]        num_q, den_q, mag_q;
  logic                neg_q;
  logic [W-1:0]        u_q, v_q, g_q;
  logic [KW-1:0]       k_q;
  logic [W-1:0]        qa_q, qd_q, ra_q, rd_q;
  logic signed [FIELD_BITS-1:0] res_num_q;
  logic [FIELD_BITS-1:0]        res_den_q;
  logic                res_lt_q, res_gt_q;

  // ---------------- shared multiplier ----------------
  logic signed [W:0]    mx, my;
  logic signed [PW-1:0] prod;
  logic [W-1:0]         bn_abs;

  assign bn_abs = W'(0) - bn_q;

  always_comb begin
    mx = zx(ad_q);
    my = zx(bd_q);
    unique case (op_i)
      DP_MUL_A: begin
        mx = sx(an_q);
        my = (act_q == ACT_MUL) ? sx(bn_q) : zx(bd_q);
      end
      DP_MUL_B: begin
        unique case (act_q) inside
          ACT_MUL: begin
            mx = zx(ad_q);
            my = zx(bd_q);
          end
          ACT_DIV: begin
            mx = zx(ad_q);
            my = bn_q[W-1] ? zx(bn_abs) : zx(bn_q);
          end
          default: begin
            mx = sx(bn_q);
            my = zx(ad_q);
          end
        endcase
      end
      default: begin
        mx = zx(ad_q);
        my = zx(bd_q);
      end
    endcase
  end

  assign prod = PW'(mx) * PW'(my);

  // ---------------- add / subtract ----------------
  logic [W-1:0] p0_lo, p1_lo, sum_w, sum_mag;

  assign p0_lo   = p0_q[W-1:0];
  assign p1_lo   = p1_q[W-1:0];
  assign sum_w   = (act_q == ACT_SUB) ? (p0_lo - p1_lo) : (p0_lo + p1_lo);
  assign sum_mag = sum_w[W-1] ? (W'(0) - sum_w) : sum_w;

  // ---------------- binary gcd ----------------
  logic         gcd_done;
  logic [W-1:0] g_w;

  assign gcd_done = (u_q == '0) || (v_q == '0) || (u_q[0] && v_q[0] && (u_q == v_q));
  assign g_w      = ((u_q == '0) ? v_q : u_q) << k_q;

  // ---------------- restoring division, both dividends by g ----------------
  logic [W:0]   ta, td, gx, ta_sub, td_sub;
  logic         ta_ge, td_ge;

  assign gx     = {1'b0, g_q};
  assign ta     = {ra_q, qa_q[W-1]};
  assign td     = {rd_q, qd_q[W-1]};
  assign ta_sub = ta - gx;
  assign td_sub = td - gx;
  assign ta_ge  = (ta >= gx);
  assign td_ge  = (td >= gx);

  // ---------------- result selection ----------------
  logic [W-1:0] n_w, d_w;
  logic         lt_w, gt_w;

  always_comb begin
    n_w  = '0;
    d_w  = '0;
    lt_w = 1'b0;
    gt_w = 1'b0;
    unique case (act_q) inside
      ACT_MUL: begin
        n_w = p0_lo;
        d_w = mult_q[W-1:0];
      end
      ACT_DIV: begin
        n_w = bn_q[W-1] ? (W'(0) - p0_lo) : p0_lo;
        d_w = mult_q[W-1:0];
      end
      ACT_ADD, ACT_SUB: begin
        if (g_q > W'(1)) begin
          n_w = neg_q ? (W'(0) - qa_q) : qa_q;
          d_w = qd_q;
        end else begin
          n_w = num_q;
          d_w = den_q;
        end
      end
      ACT_CMP: begin
        lt_w = (p0_q < mult_q);
        gt_w = (p0_q > mult_q);
      end
      default: begin
        n_w = '0;
      end
    endcase
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk_i) begin
    unique case (op_i)
      DP_LOAD: begin
        act_q <= action_i;
        an_q  <= a_num_i[W-1:0];
        ad_q  <= a_den_i[W-1:0];
        bn_q  <= b_num_i[W-1:0];
        bd_q  <= b_den_i[W-1:0];
      end
      DP_MUL_A: begin
        mult_q <= prod;
      end
      DP_MUL_B: begin
        mult_q <= prod;
        p0_q   <= mult_q;
      end
      DP_MUL_C: begin
        mult_q <= prod;
        p1_q   <= mult_q;
      end
      DP_SUM: begin
        num_q <= sum_w;
        den_q <= mult_q[W-1:0];
        mag_q <= sum_mag;
        neg_q <= sum_w[W-1];
        u_q   <= sum_mag;
        v_q   <= mult_q[W-1:0];
        k_q   <= '0;
      end
      DP_GCD: begin
        if (gcd_done) begin
          g_q  <= g_w;
          qa_q <= mag_q;
          qd_q <= den_q;
          ra_q <= '0;
          rd_q <= '0;
        end else if (!u_q[0] && !v_q[0]) begin
          u_q <= u_q >> 1;
          v_q <= v_q >> 1;
          k_q <= k_q + KW'(1);
        end else if (!u_q[0]) begin
          u_q <= u_q >> 1;
        end else if (!v_q[0]) begin
          v_q <= v_q >> 1;
        end else if (u_q > v_q) begin
          u_q <= (u_q - v_q) >> 1;
        end else begin
          v_q <= (v_q - u_q) >> 1;
        end
      end
      DP_DIV: begin
        ra_q <= ta_ge ? ta_sub[W-1:0] : ta[W-1:0];
        rd_q <= td_ge ? td_sub[W-1:0] : td[W-1:0];
        qa_q <= {qa_q[W-2:0], ta_ge};
        qd_q <= {qd_q[W-2:0], td_ge};
      end
      DP_OUT: begin
        res_num_q <= FIELD_BITS'(signed'(n_w));
        res_den_q <= FIELD_BITS'(d_w);
        res_lt_q  <= lt_w;
        res_gt_q  <= gt_w;
      end
      default: begin
        res_lt_q <= res_lt_q;
      end
    endcase
  end

  assign stat_o.gcd_done = gcd_done;
  assign stat_o.g_gt1    = (g_q > W'(1));

  assign res_num_o    = res_num_q;
  assign res_den_o    = res_den_q;
  assign is_less_o    = res_lt_q;
  assign is_greater_o = res_gt_q;

endmodule

/* rtl/core/rau_ctrl.sv */
// Controller: sequences the datapath and runs the input/output handshakes.
// Depends on rau_pkg and rational_arithmetic_unit_defines.svh.
`timescale 1ns / 1ps
`include "rational_arithmetic_unit_defines.svh"

module rau_ctrl import rau_pkg::*; #(
  parameter int WORD_BITS = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  act_t     in_action_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  dp_stat_t stat_i,
  output dp_op_e   op_o
);

  localparam int CW = $clog2(WORD_BITS);
  localparam logic [CW-1:0] CntLast = CW'(WORD_BITS - 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL_A = 4'd1;
  localparam logic [3:0] S_MUL_B = 4'd2;
  localparam logic [3:0] S_MUL_C = 4'd3;
  localparam logic [3:0] S_SUM   = 4'd4;
  localparam logic [3:0] S_GCD   = 4'd5;
  localparam logic [3:0] S_CHKG  = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  logic [3:0]    state_q, state_d;
  logic          add_q, add_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    add_d       = add_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    op_o        = DP_IDLE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_o = DP_LOAD;
          unique case (in_action_i) inside
            ACT_ADD, ACT_SUB: begin
              add_d   = 1'b1;
              state_d = S_MUL_A;
            end
            ACT_MUL, ACT_DIV, ACT_CMP: begin
              add_d   = 1'b0;
              state_d = S_MUL_A;
            end
            default: begin
              // unused codes give an all-zero result
              add_d   = 1'b0;
              state_d = S_OUT;
            end
          endcase
        end
      end
      S_MUL_A: begin
        op_o    = DP_MUL_A;
        state_d = S_MUL_B;
      end
      S_MUL_B: begin
        op_o    = DP_MUL_B;
        state_d = add_q ? S_MUL_C : S_OUT;
      end
      S_MUL_C: begin
        op_o    = DP_MUL_C;
        state_d = S_SUM;
      end
      S_SUM: begin
        op_o    = DP_SUM;
        state_d = S_GCD;
      end
      S_GCD: begin
        op_o = DP_GCD;
        if (stat_i.gcd_done) begin
          state_d = S_CHKG;
        end
      end
      S_CHKG: begin
        if (stat_i.g_gt1) begin
          cnt_d   = '0;
          state_d = S_DIV;
        end else begin
          state_d = S_OUT;
        end
      end
      S_DIV: begin
        op_o  = DP_DIV;
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == CntLast) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        // wait until the result register is free
        if (!out_valid_q || out_ready_i) begin
          op_o        = DP_OUT;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      add_q       <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      add_q       <= add_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  `RAU_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o, "accepted a transaction but still ready")
  `RAU_ASSERT_IMPL(a_no_overwrite, op_o == DP_OUT, !out_valid_q || out_ready_i, "result register overwritten before transfer")
  `RAU_ASSERT_NEXT(a_out_valid_set, op_o == DP_OUT, out_valid_o, "result written but not presented")
  `RAU_ASSERT_IMPL(a_gcd_path, state_q == S_GCD || state_q == S_DIV, add_q, "gcd reduction outside add or subtract")

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for rational_arithmetic_unit: directed table, then random traffic.
// Depends on rau_pkg and the rau_in_if / rau_out_if interfaces from the RTL.
`timescale 1ns / 1ps

module tb_top;
  import rau_pkg::*;

  localparam int   STALL_LIMIT = 2000;  // cycles without any transaction
  localparam int   DRAIN_WAIT  = 150;   // extra idle wait before the summary
  localparam int   RAND_PER_PH = 420;
  localparam act_t ACT_RSV5    = 3'd5;
  localparam act_t ACT_RSV6    = 3'd6;
  localparam act_t ACT_RSV7    = 3'd7;

  typedef struct packed {
    act_t        action;
    logic [31:0] a_num;
    logic [31:0] a_den;
    logic [31:0] b_num;
    logic [31:0] b_den;
  } frac_op_t;

  typedef struct packed {
    logic [31:0] res_num;
    logic [31:0] res_den;
    logic        is_less;
    logic        is_greater;
  } frac_res_t;

  typedef struct packed {
    frac_op_t  op;
    logic      typed;
    frac_res_t want;
  } dir_row_t;

  logic clk;
  logic rst_n;

  rau_in_if  in_if ();
  rau_out_if out_if ();

  rational_arithmetic_unit i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  frac_res_t expected_q[$];
  dir_row_t  dir_rows[$];
  int        mismatches  = 0;
  int        results_seen = 0;
  int        src_idle_pct = 0;
  int        snk_idle_pct = 0;
  int        act_count[8];

  initial begin
    clk = 1'b0;
  end
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Exact result of one operation at 32-bit word width.
  function automatic frac_res_t predict_result(input frac_op_t op);
    frac_res_t   r;
    logic [31:0] bn, num, den, mag, x, y, t;
    logic        neg;
    longint      lhs, rhs;
    r  = '0;
    bn = op.b_num;
    case (op.action)
      ACT_MUL: begin
        r.res_num = op.a_num * op.b_num;
        r.res_den = op.a_den * op.b_den;
      end
      ACT_DIV: begin
        num = op.a_num * op.b_den;
        if (bn[31]) begin
          num = 32'd0 - num;
          den = op.a_den * (32'd0 - bn);
        end else begin
          den = op.a_den * bn;
        end
        r.res_num = num;
        r.res_den = den;
      end
      ACT_ADD, ACT_SUB: begin
        if (op.action == ACT_SUB) bn = 32'd0 - bn;
        num = op.a_num * op.b_den + bn * op.a_den;
        den = op.a_den * op.b_den;
        neg = num[31];
        mag = neg ? 32'd0 - num : num;
        x   = mag;
        y   = den;
        while (y != 0) begin
          t = x % y;
          x = y;
          y = t;
        end
        if (x > 1) begin
          mag = mag / x;
          den = den / x;
          num = neg ? 32'd0 - mag : mag;
        end
        r.res_num = num;
        r.res_den = den;
      end
      ACT_CMP: begin
        lhs = longint'($signed(op.a_num)) * longint'({32'd0, op.b_den});
        rhs = longint'($signed(op.b_num)) * longint'({32'd0, op.a_den});
        r.is_less    = lhs < rhs;
        r.is_greater = lhs > rhs;
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] rand_num();
    logic [31:0] v;
    case ($urandom_range(9))
      0, 1, 2, 3, 4: v = int'($urandom_range(128)) - 64;
      5, 6, 7:       v = $urandom;
      8: begin
        case ($urandom_range(4))
          0:       v = 32'd0;
          1:       v = 32'd1;
          2:       v = 32'hFFFF_FFFF;
          3:       v = 32'h7FFF_FFFF;
          default: v = 32'h8000_0000;
        endcase
      end
      default: v = (int'($urandom_range(2000)) - 1000) * int'($urandom_range(1, 64));
    endcase
    return v;
  endfunction

  function automatic logic [31:0] rand_den();
    logic [31:0] v;
    case ($urandom_range(9))
      0, 1, 2, 3, 4: v = $urandom_range(64);
      5, 6, 7:       v = $urandom;
      8:             v = ($urandom_range(1)) ? 32'hFFFF_FFFF : 32'd0;
      default:       v = $urandom_range(4000) * $urandom_range(1, 64);
    endcase
    return v;
  endfunction

  function automatic frac_op_t rand_op();
    frac_op_t op;
    op.action = ($urandom_range(19) == 0) ? act_t'($urandom_range(ACT_RSV7, ACT_RSV5))
                                          : act_t'($urandom_range(ACT_CMP, ACT_MUL));
    op.a_num  = rand_num();
    op.a_den  = rand_den();
    op.b_num  = rand_num();
    op.b_den  = rand_den();
    return op;
  endfunction

  task automatic add_row(input act_t act, input logic [31:0] an, ad, bn, bd,
                         input int typed, input logic [31:0] wn, wd,
                         input int wl, wg);
    dir_row_t row;
    row.op   = '{act, an, ad, bn, bd};
    row.typed = (typed != 0);
    row.want = '{wn, wd, (wl != 0), (wg != 0)};
    dir_rows.push_back(row);
  endtask

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_op(input frac_op_t op, input logic typed, input frac_res_t want);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid  <= 1'b1;
    in_if.action <= op.action;
    in_if.a_num  <= op.a_num;
    in_if.a_den  <= op.a_den;
    in_if.b_num  <= op.b_num;
    in_if.b_den  <= op.b_den;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    expected_q.push_back(typed ? want : predict_result(op));
    act_count[op.action]++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(negedge clk);
    while (expected_q.size() != 0) @(negedge clk);
  endtask

  task automatic check_field(input string name, input logic [31:0] want, got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Result monitor
  always @(posedge clk) begin
    frac_res_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0d/%0d lt=%b gt=%b",
                 $time, $signed(out_if.res_num), out_if.res_den, out_if.is_less,
                 out_if.is_greater);
        mismatches++;
      end else begin
        want = expected_q.pop_front();
        check_field("res_num", want.res_num, out_if.res_num);
        check_field("res_den", want.res_den, out_if.res_den);
        check_field("is_less", 32'(want.is_less), 32'(out_if.is_less));
        check_field("is_greater", 32'(want.is_greater), 32'(out_if.is_greater));
      end
    end
  end

  // Result-side backpressure
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Watchdog: counts cycles with no transaction on either channel
  initial begin
    int stall_cycles;
    stall_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    int src_pct[3];
    int snk_pct[3];
    src_pct = '{12, 87, 0};
    snk_pct = '{87, 12, 0};
    foreach (act_count[i]) act_count[i] = 0;
    rst_n        = 1'b0;
    in_if.valid  = 1'b0;
    in_if.action = ACT_MUL;
    in_if.a_num  = '0;
    in_if.a_den  = '0;
    in_if.b_num  = '0;
    in_if.b_den  = '0;

    // extremes, every action, zero numerators and denominators, sign handling
    add_row(ACT_MUL, 1, 1, 1, 1, 1, 1, 1, 0, 0);
    add_row(ACT_MUL, 32'h7FFF_FFFF, '1, 32'h7FFF_FFFF, '1, 1, 1, 1, 0, 0);
    add_row(ACT_MUL, 32'h8000_0000, 0, 32'h8000_0000, 0, 1, 0, 0, 0, 0);
    add_row(ACT_MUL, -3, 5, 7, 11, 0, 0, 0, 0, 0);
    add_row(ACT_DIV, 3, 4, -5, 7, 1, -21, 20, 0, 0);
    add_row(ACT_DIV, 1, 2, 3, 5, 1, 5, 6, 0, 0);
    add_row(ACT_DIV, 1, 1, 32'h8000_0000, 1, 1, -1, 32'h8000_0000, 0, 0);
    add_row(ACT_DIV, -7, 0, 0, 3, 0, 0, 0, 0, 0);
    add_row(ACT_ADD, 1, 2, 1, 3, 1, 5, 6, 0, 0);
    add_row(ACT_ADD, 1, 4, 1, 4, 1, 1, 2, 0, 0);
    add_row(ACT_SUB, 1, 2, 1, 2, 1, 0, 1, 0, 0);
    add_row(ACT_ADD, 0, 0, 0, 0, 1, 0, 0, 0, 0);
    add_row(ACT_ADD, 0, 1, 0, 1, 1, 0, 1, 0, 0);
    add_row(ACT_SUB, 1, 3, 2, 3, 1, -1, 3, 0, 0);
    add_row(ACT_ADD, 3, 2, 5, 0, 1, 1, 0, 0, 0);
    add_row(ACT_ADD, -6, 4, 2, 4, 1, -1, 1, 0, 0);
    add_row(ACT_ADD, 32'h8000_0000, 1, 0, 1, 1, 32'h8000_0000, 1, 0, 0);
    add_row(ACT_SUB, 0, 1, 32'h8000_0000, 1, 0, 0, 0, 0, 0);
    add_row(ACT_ADD, 32'h7FFF_FFFF, '1, 32'h7FFF_FFFF, '1, 0, 0, 0, 0, 0);
    add_row(ACT_CMP, 1, 2, 1, 3, 1, 0, 0, 0, 1);
    add_row(ACT_CMP, 1, 3, 1, 2, 1, 0, 0, 1, 0);
    add_row(ACT_CMP, 2, 4, 1, 2, 1, 0, 0, 0, 0);
    add_row(ACT_CMP, 32'h8000_0000, '1, 32'h7FFF_FFFF, '1, 1, 0, 0, 1, 0);
    add_row(ACT_CMP, -1, 1, 1, 1, 1, 0, 0, 1, 0);
    add_row(ACT_RSV5, '1, '1, '1, '1, 1, 0, 0, 0, 0);
    add_row(ACT_RSV6, 32'h8000_0000, '1, 32'h7FFF_FFFF, 0, 1, 0, 0, 0, 0);
    add_row(ACT_RSV7, 5, 6, 7, 8, 1, 0, 0, 0, 0);

    src_idle_pct = src_pct[0];
    snk_idle_pct = snk_pct[0];
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) send_op(dir_rows[i].op, dir_rows[i].typed, dir_rows[i].want);
    wait_drained();

    for (int ph = 0; ph < 3; ph++) begin
      src_idle_pct = src_pct[ph];
      snk_idle_pct = snk_pct[ph];
      for (int i = 0; i < RAND_PER_PH; i++) begin
        if ($urandom_range(99) == 0) wait_drained();
        send_op(rand_op(), 1'b0, '0);
      end
      wait_drained();
    end

    repeat (DRAIN_WAIT) @(negedge clk);
    $display("Checked %0d results: mul %0d, div %0d, add %0d, sub %0d, cmp %0d, unused codes %0d",
             results_seen, act_count[ACT_MUL], act_count[ACT_DIV], act_count[ACT_ADD],
             act_count[ACT_SUB], act_count[ACT_CMP],
             act_count[ACT_RSV5] + act_count[ACT_RSV6] + act_count[ACT_RSV7]);
    $display("Traffic ran under sender-idle, receiver-stall and back-to-back handshakes");
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
